// File: rtl/fsr_pkg.sv
// shared types and constants for the fiat-shamir round unit
// no dependencies
package fsr_pkg;

	localparam int WIDTH  = 32;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [31:0] OUT_MASK = 32'((64'd1 << WIDTH) - 64'd1);

	localparam logic [1:0] REG_PRIME_P = 2'd0;
	localparam logic [1:0] REG_PRIME_Q = 2'd1;
	localparam logic [1:0] REG_SECRET  = 2'd2;

	typedef struct packed {
		logic [31:0] commitment;
		logic        challenge;
	} item_t;

	typedef struct packed {
		logic [31:0] witness;
		logic [31:0] response;
		logic [31:0] public_value;
		logic        valid_res;
	} result_t;

	typedef struct packed {
		logic        go;
		logic        len64;
		logic [63:0] val;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} mod_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_S,
		ST_MUL_P,
		ST_RED_P,
		ST_RED_X,
		ST_MUL_W,
		ST_RED_W,
		ST_MUL_R,
		ST_RED_R
	} state_t;

endpackage

// File: rtl/fsr_modred.sv
// bit-serial modular reduction, one dividend bit per cycle
// depends on fsr_pkg
module fsr_modred (
	input  logic             clk,
	input  logic             arst_n,
	input  fsr_pkg::mod_req_t req,
	input  logic [31:0]      n,
	output fsr_pkg::mod_rsp_t rsp
);

	logic [31:0] rem_q;
	logic [63:0] sh_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [31:0] next_rem;

	always_comb begin
		trial    = {rem_q, sh_q[63]};
		diff     = trial - {1'b0, n};
		next_rem = (trial >= {1'b0, n}) ? diff[31:0] : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.go) begin
			cnt_q  <= req.len64 ? 7'd64 : 7'd32;
			done_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			sh_q  <= req.len64 ? req.val : {req.val[31:0], 32'd0};
			rem_q <= '0;
		end else if (cnt_q != 7'd0) begin
			sh_q  <= {sh_q[62:0], 1'b0};
			rem_q <= next_rem;
		end
	end

	// a zero modulus takes every residue as zero
	assign rsp.done = done_q;
	assign rsp.res  = (n == 32'd0) ? 32'd0 : rem_q;

endmodule

// File: rtl/fsr_front.sv
// front end: takes commands and queues them for the back end
// depends on fsr_pkg
module fsr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  fsr_pkg::item_t item,
	output logic          busy,
	input  logic          pop,
	output fsr_pkg::item_t head,
	output logic          empty
);

	fsr_pkg::item_t                mem_q [fsr_pkg::QDEPTH];
	logic [fsr_pkg::QAW-1:0]       wr_q;
	logic [fsr_pkg::QAW-1:0]       rd_q;
	logic [fsr_pkg::QAW:0]         cnt_q;
	logic                          push;
	logic                          take;

	assign busy  = (cnt_q == (fsr_pkg::QAW+1)'(fsr_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign push  = start & ~busy;
	assign take  = pop & ~empty;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + (fsr_pkg::QAW)'(1);
			if (take) rd_q <= rd_q + (fsr_pkg::QAW)'(1);
			if (push && !take) cnt_q <= cnt_q + (fsr_pkg::QAW+1)'(1);
			else if (take && !push) cnt_q <= cnt_q - (fsr_pkg::QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= item;
	end

endmodule

// File: rtl/fsr_back.sv
// back end: sequences the modular products of one round
// depends on fsr_pkg, fsr_modred
module fsr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  fsr_pkg::item_t   head,
	output logic             pop,
	input  logic [31:0]      n,
	input  logic [31:0]      secret,
	output fsr_pkg::result_t result,
	output logic             done
);

	fsr_pkg::state_t   state_q, state_d;
	fsr_pkg::mod_req_t req;
	fsr_pkg::mod_rsp_t rsp;
	logic [63:0] op_q;
	logic        len_q;
	logic        go_q;
	logic [31:0] s_q, pub_q, x_q, wit_q, commit_q;
	logic        e_q;
	fsr_pkg::result_t result_q;
	logic        done_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	assign req.go    = go_q;
	assign req.len64 = len_q;
	assign req.val   = op_q;

	fsr_modred u_modred (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.n      (n),
		.rsp    (rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsr_pkg::ST_IDLE:  if (!empty) state_d = fsr_pkg::ST_RED_S;
			fsr_pkg::ST_RED_S: if (rsp.done) state_d = fsr_pkg::ST_MUL_P;
			fsr_pkg::ST_MUL_P: state_d = fsr_pkg::ST_RED_P;
			fsr_pkg::ST_RED_P: if (rsp.done) state_d = fsr_pkg::ST_RED_X;
			fsr_pkg::ST_RED_X: if (rsp.done) state_d = fsr_pkg::ST_MUL_W;
			fsr_pkg::ST_MUL_W: state_d = fsr_pkg::ST_RED_W;
			fsr_pkg::ST_RED_W: begin
				if (rsp.done) state_d = e_q ? fsr_pkg::ST_MUL_R : fsr_pkg::ST_IDLE;
			end
			fsr_pkg::ST_MUL_R: state_d = fsr_pkg::ST_RED_R;
			fsr_pkg::ST_RED_R: if (rsp.done) state_d = fsr_pkg::ST_IDLE;
			default:           state_d = fsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		mul_a = x_q;
		mul_b = x_q;
		unique case (state_q)
			fsr_pkg::ST_IDLE:  pop = ~empty;
			fsr_pkg::ST_MUL_P: begin
				mul_a = s_q;
				mul_b = s_q;
			end
			fsr_pkg::ST_MUL_R: mul_b = s_q;
			default: ;
		endcase
	end

	assign prod = {32'd0, mul_a} * {32'd0, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsr_pkg::ST_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
			case (state_q)
				fsr_pkg::ST_IDLE:  go_q <= ~empty;
				fsr_pkg::ST_MUL_P, fsr_pkg::ST_MUL_W, fsr_pkg::ST_MUL_R: go_q <= 1'b1;
				fsr_pkg::ST_RED_P: go_q <= rsp.done;
				fsr_pkg::ST_RED_W: done_q <= rsp.done & ~e_q;
				fsr_pkg::ST_RED_R: done_q <= rsp.done;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fsr_pkg::ST_IDLE: begin
				commit_q <= head.commitment;
				e_q      <= head.challenge;
				op_q     <= {32'd0, secret};
				len_q    <= 1'b0;
			end
			fsr_pkg::ST_RED_S: if (rsp.done) s_q <= rsp.res;
			fsr_pkg::ST_MUL_P, fsr_pkg::ST_MUL_W, fsr_pkg::ST_MUL_R: begin
				op_q  <= prod;
				len_q <= 1'b1;
			end
			fsr_pkg::ST_RED_P: begin
				if (rsp.done) pub_q <= rsp.res;
				op_q  <= {32'd0, commit_q};
				len_q <= 1'b0;
			end
			fsr_pkg::ST_RED_X: if (rsp.done) x_q <= rsp.res;
			fsr_pkg::ST_RED_W: begin
				if (rsp.done) begin
					wit_q <= rsp.res;
					result_q.witness      <= rsp.res & fsr_pkg::OUT_MASK;
					result_q.response     <= x_q & fsr_pkg::OUT_MASK;
					result_q.public_value <= pub_q & fsr_pkg::OUT_MASK;
					result_q.valid_res    <= 1'b1;
				end
			end
			fsr_pkg::ST_RED_R: begin
				if (rsp.done) begin
					result_q.witness      <= wit_q & fsr_pkg::OUT_MASK;
					result_q.response     <= rsp.res & fsr_pkg::OUT_MASK;
					result_q.public_value <= pub_q & fsr_pkg::OUT_MASK;
					// (x*s)^2 and x^2 * s^2 agree mod n, so the check always holds
					result_q.valid_res    <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// File: rtl/fiat_shamir_round_unit.sv
// Fiat-Shamir identification round unit. One round per command: start is taken
// when busy is low and up to four commands queue up while earlier rounds run.
// Each round runs on the one bit-serial modular reduction unit: four reductions
// with challenge 0 and five with challenge 1 (secret, commitment, each product),
// with a multiply step before each product and a step to take the command from
// the queue. The result shows for one cycle with done high; the receiver cannot
// stall it. Configuration is written through cfg_we / cfg_idx / cfg_wdata; the
// user must write it only while idle, and the block does not enforce this.
// depends on fsr_pkg, fsr_front, fsr_back
module fiat_shamir_round_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fsr_pkg::item_t   item,
	output logic             busy,
	output fsr_pkg::result_t result,
	output logic             done,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_wdata
);

	logic [15:0] prime_p_q;
	logic [15:0] prime_q_q;
	logic [31:0] secret_q;
	logic [31:0] n_q;
	logic        pop;
	logic        empty;
	fsr_pkg::item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_p_q <= 16'd61;
			prime_q_q <= 16'd53;
			secret_q  <= 32'd7;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fsr_pkg::REG_PRIME_P: prime_p_q <= cfg_wdata[15:0];
				fsr_pkg::REG_PRIME_Q: prime_q_q <= cfg_wdata[15:0];
				fsr_pkg::REG_SECRET:  secret_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// modulus is the registered product of the two prime registers
	always_ff @(posedge clk) begin
		n_q <= {16'd0, prime_p_q} * {16'd0, prime_q_q};
	end

	fsr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	fsr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.n      (n_q),
		.secret (secret_q),
		.result (result),
		.done   (done)
	);

endmodule

// File: tb/fsr_checker.sv
`timescale 1ns / 100ps
// checker for the fiat-shamir round unit: watches command and result transfers,
// predicts each round from its own copy of the registers; depends on fsr_pkg
module fsr_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  fsr_pkg::item_t   item,
	input  logic             done,
	input  fsr_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_wdata,
	output int               fail_count,
	output int               pending
);

	logic [15:0] p_reg, q_reg;
	logic [31:0] s_reg;
	fsr_pkg::result_t rounds_due[$];

	function automatic logic [63:0] reduce(logic [63:0] v, logic [63:0] n);
		if (n == 0) return 64'd0;
		return v % n;
	endfunction

	function automatic fsr_pkg::result_t predict_round(fsr_pkg::item_t it);
		fsr_pkg::result_t r;
		logic [63:0] n, x, s, pub, wit, resp, lhs, rhs;
		n = {48'd0, p_reg} * {48'd0, q_reg};
		x = reduce({32'd0, it.commitment}, n);
		s = reduce({32'd0, s_reg}, n);
		pub = reduce(s * s, n);
		wit = reduce(x * x, n);
		resp = it.challenge ? reduce(x * s, n) : x;
		lhs = reduce(resp * resp, n);
		rhs = it.challenge ? reduce(wit * pub, n) : wit;
		r.witness = wit[31:0];
		r.response = resp[31:0];
		r.public_value = pub[31:0];
		r.valid_res = (lhs == rhs);
		return r;
	endfunction

	assign pending = rounds_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_reg <= 16'd61;
			q_reg <= 16'd53;
			s_reg <= 32'd7;
			fail_count <= 0;
			rounds_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					fsr_pkg::REG_PRIME_P: p_reg <= cfg_wdata[15:0];
					fsr_pkg::REG_PRIME_Q: q_reg <= cfg_wdata[15:0];
					fsr_pkg::REG_SECRET:  s_reg <= cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				rounds_due.push_back(predict_round(item));
			if (done) begin
				if (rounds_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					fsr_pkg::result_t exp_r;
					exp_r = rounds_due.pop_front();
					if (exp_r !== result) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the fiat-shamir round unit
// depends on fsr_pkg, fiat_shamir_round_unit, fsr_checker
module tb;

	logic clk, arst_n, start, busy, done, cfg_we;
	fsr_pkg::item_t item;
	fsr_pkg::result_t result;
	logic [1:0] cfg_idx;
	logic [31:0] cfg_wdata;
	int fail_count, pending;
	bit quiet;

	fiat_shamir_round_unit i_dut (.*);
	fsr_checker i_chk (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// holds start until the transfer happens; returns at the accepting edge
	task automatic send_round(logic [31:0] c, logic e);
		if (!quiet)
			while ($urandom_range(99) < 15) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		item <= '{commitment: c, challenge: e};
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] p, logic [15:0] q, logic [31:0] s);
		write_reg(fsr_pkg::REG_PRIME_P, {16'd0, p});
		write_reg(fsr_pkg::REG_PRIME_Q, {16'd0, q});
		write_reg(fsr_pkg::REG_SECRET, s);
	endtask

	function automatic logic [31:0] rand_commit();
		case ($urandom_range(3))
			0: return $urandom_range(20);
			1: return 32'hFFFF_FFFF - $urandom_range(20);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#20_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		logic [15:0] p, q;
		logic [31:0] s;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = fsr_pkg::REG_PRIME_P;
		cfg_wdata = '0;
		quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers, field extremes, both challenges
		send_round(32'd0, 1'b0);
		send_round(32'd0, 1'b1);
		send_round(32'hFFFF_FFFF, 1'b0);
		send_round(32'hFFFF_FFFF, 1'b1);
		send_round(32'd3233, 1'b1);
		send_round(32'd3234, 1'b0);
		send_round(32'hAAAA_5555, 1'b1);
		drain();
		// zero modulus
		set_regs(16'd0, 16'd53, 32'd7);
		send_round(32'd12345, 1'b1);
		send_round(32'd12345, 1'b0);
		drain();
		// largest modulus, secret at the top and not below N
		set_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_round(32'hFFFF_FFFF, 1'b1);
		send_round(32'hFFFE_0001, 1'b1);
		send_round(32'h5555_AAAA, 1'b0);
		drain();
		// a non-prime factor, secret zero, unused register index
		set_regs(16'd2, 16'd4, 32'd0);
		write_reg(2'd3, 32'hDEAD_BEEF);
		send_round(32'd9, 1'b1);
		send_round(32'd8, 1'b0);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin
					p = 16'($urandom_range(2, 300));
					q = 16'($urandom_range(2, 300));
				end
				1: begin
					p = 16'($urandom);
					q = 16'($urandom);
				end
				2: begin
					p = 16'(32'hFFFF - $urandom_range(5));
					q = 16'($urandom_range(2, 65535));
				end
				default: begin
					p = 16'($urandom_range(1));
					q = 16'($urandom);
				end
			endcase
			s = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
			set_regs(p, q, s);
			quiet = (ph == 5);
			for (int k = 0; k < 100; k++)
				send_round(rand_commit(), 1'($urandom_range(1)));
			drain();
		end

		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
